/* sv/tsp_pkg.sv */
// Shared types, constants and codes for the tone sequence player.
// No dependencies; imported by every module of the block.
package tsp_pkg;

   localparam int LIST_DEPTH = 16;
   localparam int IDX_W      = $clog2(LIST_DEPTH);
   localparam int POS_W      = $clog2(LIST_DEPTH + 2);

   localparam int CLK_W  = 28;
   localparam int FREQ_W = 16;
   localparam int DUR_W  = 16;
   localparam int TICK_W = 20;
   localparam int CNT_W  = $clog2(CLK_W);

   localparam logic [CLK_W-1:0]  CLOCK_RESET   = 28'd48000000;
   localparam logic [FREQ_W-1:0] SILENCE_LIMIT = 16'd200;

   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_START = 2'd2;

   typedef struct packed {
      logic [1:0]        func;
      logic [3:0]        entry_index;
      logic [FREQ_W-1:0] tone_freq;
      logic [DUR_W-1:0]  tone_duration_ms;
   } req_type;

   typedef struct packed {
      logic        pwm_enable;
      logic [15:0] prescale_load;
      logic [15:0] period_load;
      logic [14:0] compare_load;
      logic        new_tone;
      logic        playing;
   } rsp_type;

   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic [DUR_W-1:0]  dur;
   } tone_entry_type;

   typedef struct packed {
      logic              start;
      logic [CLK_W-1:0]  dividend;
      logic [FREQ_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [CLK_W-1:0] quotient;
   } div_rsp_type;

endpackage

/* sv/tone_sequence_player_core.sv */
// Path: an accepted item is registered and passes ST_EXEC and ST_RESULT into the output
// register; a tone change with division also passes ST_DIV_RAW and ST_DIV_PER, two
// 28-step passes through the serial divider.
// Flow: one item at a time; the next transfer can be taken in the cycle after the result
// enters the output register, later while rsp_stall holds a full output register.
// Reset: list reads as all zero at once, playback idle, output off, clock_hz 48000000.
module tone_sequence_player_core import tsp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CLK_W-1:0] csr_data
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_EXEC    = 3'd1;
   localparam logic [2:0] ST_DIV_RAW = 3'd2;
   localparam logic [2:0] ST_DIV_PER = 3'd3;
   localparam logic [2:0] ST_RESULT  = 3'd4;

   logic [2:0]        state_ff, state_in;
   req_type           item_ff;
   logic [CLK_W-1:0]  clock_hz_ff;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [TICK_W-1:0] ticks_ff, ticks_in;
   logic              en_ff, en_in;
   logic [15:0]       pre_ff, pre_in;
   logic [15:0]       per_ff, per_in;
   logic [14:0]       cmp_ff, cmp_in;
   logic              fresh_ff, fresh_in;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              accept;
   logic              wr_en;
   logic [POS_W-1:0]  fetch_id;
   tone_entry_type    entry;
   div_req_type       div_req;
   div_rsp_type       div_rsp;
   logic              rsp_load;
   logic [TICK_W-1:0] dur_ext;
   logic [15:0]       per_q;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign wr_en     = accept && (req_data.func == FUNC_WRITE) &&
                      (int'(req_data.entry_index) < LIST_DEPTH);
   assign fetch_id  = pos_ff - POS_W'(1);

   tsp_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(req_data.entry_index)),
      .wr_data ({req_data.tone_freq, req_data.tone_duration_ms}),
      .rd_en   (accept),
      .rd_addr (fetch_id[IDX_W-1:0]),
      .rd_data (entry)
   );

   tsp_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      ticks_in = ticks_ff;
      en_in    = en_ff;
      pre_in   = pre_ff;
      per_in   = per_ff;
      cmp_in   = cmp_ff;
      fresh_in = fresh_ff;
      div_req  = '0;
      dur_ext  = TICK_W'(entry.dur);
      per_q    = div_rsp.quotient[15:0];
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            fresh_in = 1'b0;
            state_in = ST_RESULT;
            if (item_ff.func == FUNC_START) begin
               pos_in   = POS_W'(1);
               ticks_in = '0;
            end else if (item_ff.func == FUNC_TICK && pos_ff != '0) begin
               if (ticks_ff == '0) begin
                  if (int'(fetch_id) >= LIST_DEPTH || entry.dur == '0) begin
                     en_in  = 1'b0;
                     pos_in = '0;
                  end else begin
                     ticks_in = (dur_ext << 3) + (dur_ext << 1);
                     pos_in   = pos_ff + POS_W'(1);
                     if (entry.freq <= SILENCE_LIMIT) begin
                        en_in = 1'b0;
                     end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = clock_hz_ff;
                        div_req.divisor  = entry.freq;
                        state_in         = ST_DIV_RAW;
                     end
                  end
               end else begin
                  ticks_in = ticks_ff - TICK_W'(1);
               end
            end
         end
         ST_DIV_RAW: begin
            if (div_rsp.done) begin
               pre_in           = 16'(div_rsp.quotient[CLK_W-1:16]);
               div_req.start    = 1'b1;
               div_req.dividend = div_rsp.quotient;
               div_req.divisor  = 16'(div_rsp.quotient[CLK_W-1:16]) + 16'd1;
               state_in         = ST_DIV_PER;
            end
         end
         ST_DIV_PER: begin
            if (div_rsp.done) begin
               per_in   = per_q - 16'd1;
               cmp_in   = per_q[15:1];
               en_in    = 1'b1;
               fresh_in = 1'b1;
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
      if (rsp_load) begin
         rsp_ff.pwm_enable    <= en_ff;
         rsp_ff.prescale_load <= pre_ff;
         rsp_ff.period_load   <= per_ff;
         rsp_ff.compare_load  <= cmp_ff;
         rsp_ff.new_tone      <= fresh_ff;
         rsp_ff.playing       <= (pos_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clock_hz_ff  <= CLOCK_RESET;
         pos_ff       <= '0;
         ticks_ff     <= '0;
         en_ff        <= 1'b0;
         pre_ff       <= '0;
         per_ff       <= '0;
         cmp_ff       <= '0;
         fresh_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         ticks_ff     <= ticks_in;
         en_ff        <= en_in;
         pre_ff       <= pre_in;
         per_ff       <= per_in;
         cmp_ff       <= cmp_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            clock_hz_ff <= csr_data;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* sv/tsp_store.sv */
// Tone list memory: one write port, one read port, registered read data.
// Per-entry valid bits make unwritten entries read as zero after reset. Uses tsp_pkg.
module tsp_store import tsp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  tone_entry_type wr_data,
   input  logic           rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output tone_entry_type rd_data
);

   tone_entry_type          mem [LIST_DEPTH];
   logic [LIST_DEPTH-1:0]   valid_ff;
   tone_entry_type          rd_data_ff;
   logic                    rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

/* sv/tsp_div.sv */
// Restoring serial divider, one quotient bit per cycle, shared by both divisions.
// Uses tsp_pkg for operand widths and request/response types.
module tsp_div import tsp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [CLK_W-1:0]  quo_ff, quo_in;
   logic [FREQ_W-1:0] rem_ff, rem_in;
   logic [FREQ_W-1:0] dvs_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [FREQ_W:0]   rem_sh;
   logic [FREQ_W:0]   diff;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[CLK_W-1]};
      diff    = rem_sh - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(CLK_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[FREQ_W]) begin
            rem_in = diff[FREQ_W-1:0];
            quo_in = {quo_ff[CLK_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[FREQ_W-1:0];
            quo_in = {quo_ff[CLK_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (req.start) begin
         dvs_ff <= req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

/* test/tone_sequence_player_core_test.sv */
// Testbench for tone_sequence_player_core: directed and random tone lists, played against a
// cycle-free prediction of timer loads, with random request idling and result stalls.
// Depends on tsp_pkg and the tone_sequence_player_core RTL with tsp_store and tsp_div.
module tone_sequence_player_core_test;
   import tsp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] FUNC_UNUSED        = 2'd3;
   localparam int unsigned PRESCALE_SPAN     = 65536;
   localparam int unsigned TICKS_PER_MS      = 10;
   localparam int unsigned CLOCK_MIN         = 1000000;
   localparam int unsigned CLOCK_MAX         = 200000000;
   localparam int unsigned ZERO_PERIOD_CLOCK = 50000;
   localparam int unsigned TONE_CHANGE_CYCLES = 70;
   localparam int unsigned ITEM_TARGET       = 700;
   localparam int unsigned IDLE_PERCENT      = 36;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CLK_W-1:0] csr_data = '0;

   bit          steady_flow = 1'b0;
   int unsigned failures = 0;
   int unsigned items_sent = 0;
   int unsigned results_seen = 0;
   int unsigned tones_loaded = 0;
   int unsigned rate_writes = 0;

   rsp_type player_outputs_due[$];

   logic [CLK_W-1:0]  model_clock_hz = CLOCK_RESET;
   logic [FREQ_W-1:0] model_freq[LIST_DEPTH] = '{default: '0};
   logic [DUR_W-1:0]  model_dur[LIST_DEPTH] = '{default: '0};
   int unsigned       model_position = 0;
   int unsigned       model_ticks = 0;
   logic              model_enable = 1'b0;
   logic [15:0]       model_prescale = '0;
   logic [15:0]       model_period = '0;
   logic [14:0]       model_compare = '0;

   tone_sequence_player_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic bit load_timer(logic [FREQ_W-1:0] freq);
      int unsigned raw;
      int unsigned pre;
      int unsigned per;
      if (freq <= SILENCE_LIMIT) begin
         model_enable = 1'b0;
         return 1'b0;
      end
      raw = int'(model_clock_hz) / int'(freq);
      pre = raw / PRESCALE_SPAN + 1;
      per = raw / pre;
      model_prescale = 16'(pre - 1);
      model_period = 16'(per - 1);
      model_compare = 15'(per / 2);
      model_enable = 1'b1;
      return 1'b1;
   endfunction

   function automatic rsp_type advance_player(req_type item);
      rsp_type     out;
      bit          fresh;
      int unsigned slot;
      fresh = 1'b0;
      case (item.func)
         FUNC_WRITE: begin
            if (int'(item.entry_index) < LIST_DEPTH) begin
               model_freq[item.entry_index] = item.tone_freq;
               model_dur[item.entry_index] = item.tone_duration_ms;
            end
         end
         FUNC_START: begin
            model_position = 1;
            model_ticks = 0;
         end
         FUNC_TICK: begin
            if (model_position != 0) begin
               if (model_ticks == 0) begin
                  slot = model_position - 1;
                  if (slot >= LIST_DEPTH || model_dur[slot] == 0) begin
                     model_enable = 1'b0;
                     model_position = 0;
                  end else begin
                     model_ticks = TICKS_PER_MS * model_dur[slot];
                     fresh = load_timer(model_freq[slot]);
                     model_position++;
                  end
               end else begin
                  model_ticks--;
               end
            end
         end
         default: begin
         end
      endcase
      out.pwm_enable = model_enable;
      out.prescale_load = model_prescale;
      out.period_load = model_period;
      out.compare_load = model_compare;
      out.new_tone = fresh;
      out.playing = (model_position != 0);
      return out;
   endfunction

   function automatic void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (player_outputs_due.size() == 0) begin
            $error("result transfer with no expected result pending");
            failures++;
         end else begin
            want = player_outputs_due.pop_front();
            results_seen++;
            if (want.new_tone)
               tones_loaded++;
            check_field("pwm_enable", want.pwm_enable, rsp_data.pwm_enable);
            check_field("prescale_load", want.prescale_load, rsp_data.prescale_load);
            check_field("period_load", want.period_load, rsp_data.period_load);
            check_field("compare_load", want.compare_load, rsp_data.compare_load);
            check_field("new_tone", want.new_tone, rsp_data.new_tone);
            check_field("playing", want.playing, rsp_data.playing);
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !steady_flow && ($urandom_range(99) < IDLE_PERCENT);
   end

   task automatic send_item(logic [1:0] func, logic [3:0] index, logic [FREQ_W-1:0] freq,
                            logic [DUR_W-1:0] dur);
      req_type item;
      item.func = func;
      item.entry_index = index;
      item.tone_freq = freq;
      item.tone_duration_ms = dur;
      while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = item;
      do
         @(posedge clock);
      while (req_stall);
      player_outputs_due.push_back(advance_player(item));
      if (func != FUNC_UNUSED)
         items_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_tick();
      send_item(FUNC_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic send_start();
      send_item(FUNC_START, 4'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic send_unused();
      send_item(FUNC_UNUSED, 4'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic write_entry(logic [3:0] index, logic [FREQ_W-1:0] freq, logic [DUR_W-1:0] dur);
      send_item(FUNC_WRITE, index, freq, dur);
   endtask

   task automatic drain_results();
      while (player_outputs_due.size() != 0)
         @(negedge clock);
      repeat (TONE_CHANGE_CYCLES) @(negedge clock);
   endtask

   task automatic write_clock_rate(logic [CLK_W-1:0] rate);
      drain_results();
      csr_valid = 1'b1;
      csr_data = rate;
      do
         @(posedge clock);
      while (!csr_ready);
      model_clock_hz = rate;
      rate_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [FREQ_W-1:0] pick_tone_freq();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 15)
         return 16'($urandom_range(SILENCE_LIMIT));
      if (pick < 18)
         return SILENCE_LIMIT + 16'd1;
      if (pick < 21)
         return 16'hFFFF;
      return 16'($urandom_range(16'hFFFF, SILENCE_LIMIT + 1));
   endfunction

   task automatic test_idle_behavior();
      send_tick();
      send_unused();
      send_start();
      send_tick();
      send_tick();
   endtask

   task automatic test_field_extremes();
      write_entry(4'd15, 16'hFFFF, 16'hFFFF);
      write_entry(4'd0, 16'hFFFF, 16'hFFFF);
      send_start();
      send_tick();
      send_tick();
      send_unused();
      write_entry(4'd0, SILENCE_LIMIT, 16'd1);
      send_start();
      send_tick();
      send_tick();
      write_entry(4'd0, SILENCE_LIMIT + 16'd1, 16'd1);
      send_start();
      send_tick();
   endtask

   task automatic test_clock_settings();
      write_clock_rate(CLK_W'(ZERO_PERIOD_CLOCK));
      write_entry(4'd0, 16'd60000, 16'd1);
      send_start();
      send_tick();
      write_clock_rate(CLK_W'(CLOCK_MIN));
      send_start();
      send_tick();
      write_clock_rate(CLK_W'(CLOCK_MAX));
      write_entry(4'd0, SILENCE_LIMIT + 16'd1, 16'd1);
      send_start();
      send_tick();
      write_clock_rate(CLOCK_RESET);
   endtask

   task automatic test_list_end();
      for (int i = 0; i < LIST_DEPTH; i++)
         write_entry(4'(i), pick_tone_freq(), 16'd1);
      send_start();
      while (model_position != 0)
         send_tick();
   endtask

   task automatic test_random_sequences();
      int unsigned length;
      int unsigned restarts;
      int unsigned stop_after;
      int unsigned step;
      int unsigned pick;
      while (items_sent < ITEM_TARGET) begin
         steady_flow = (items_sent >= 300 && items_sent < 420);
         if ($urandom_range(9) == 0)
            write_clock_rate(CLK_W'($urandom_range(CLOCK_MAX, CLOCK_MIN)));
         repeat ($urandom_range(3))
            send_item(2'($urandom), 4'($urandom), 16'($urandom), 16'($urandom));
         length = $urandom_range(4, 1);
         for (int i = 0; i < length; i++)
            write_entry(4'(i), pick_tone_freq(), 16'($urandom_range(2, 1)));
         write_entry(4'(length), pick_tone_freq(), 16'd0);
         send_start();
         restarts = 0;
         step = 0;
         stop_after = ($urandom_range(5) == 0) ? $urandom_range(30, 1) : 1000;
         while (model_position != 0 && step < stop_after) begin
            pick = $urandom_range(99);
            if (pick < 86) begin
               send_tick();
            end else if (pick < 91) begin
               send_unused();
            end else if (pick < 96) begin
               write_entry(4'($urandom_range(length - 1)), pick_tone_freq(),
                           16'($urandom_range(2, 1)));
            end else if (restarts == 0) begin
               send_start();
               restarts++;
            end
            step++;
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_idle_behavior();
      test_field_extremes();
      test_clock_settings();
      test_list_end();
      test_random_sequences();
      drain_results();
      $display("Covered %0d transfers and %0d results, %0d of them tone loads, over %0d clock rates",
               items_sent, results_seen, tones_loaded, rate_writes + 1);
      if (failures == 0)
         $display("tone_sequence_player_core_test: PASS");
      else
         $display("tone_sequence_player_core_test: FAIL");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("tone_sequence_player_core_test: FAIL");
      $finish;
   end

endmodule
